// ----- rtl/core/frame_fragment_header_generator_assert.svh -----
// ----------------------------------------------------------------------------
// frame fragment header generator assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef FRAME_FRAGMENT_HEADER_GENERATOR_ASSERT_SVH
`define FRAME_FRAGMENT_HEADER_GENERATOR_ASSERT_SVH

// same-cycle implication
`define FFHG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFHG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ffhg_pkg.sv -----
// ----------------------------------------------------------------------------
// ffhg_pkg
// shared constants, types and the byte-wide crc-32 update for the
// frame fragment header generator
// ----------------------------------------------------------------------------
`default_nettype none

package ffhg_pkg;

   localparam int unsigned MAX_PAYLOAD_BYTES_DEFAULT = 1024;

   localparam int unsigned HDR_LEN    = 30;
   localparam int unsigned HDR_BITS   = 8 * HDR_LEN;
   localparam int unsigned OFFSET_W   = 5;
   localparam int unsigned SIZE_W     = 26;
   localparam int unsigned POS_W      = 27;
   localparam int unsigned NUM_W      = 16;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned DIVIDEND_W = 28;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [OFFSET_W-1:0] COUNT_OFFSET = OFFSET_W'(20);
   localparam logic [OFFSET_W-1:0] LAST_OFFSET  = OFFSET_W'(HDR_LEN - 1);

   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

   typedef enum logic [1:0] {
      CSR_MAGIC   = 2'd0,
      CSR_VERSION = 2'd1,
      CSR_FLAGS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic empty;
   } div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] quotient;
   } div_status_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'h000000, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/frame_fragment_header_generator.sv -----
// ----------------------------------------------------------------------------
// frame_fragment_header_generator
// Cuts a byte stream into fragments of at most MAX_PAYLOAD_BYTES, keeps a
// reflected crc-32 per fragment and emits a 30-byte big-endian header for
// every completed fragment and every empty-frame marker.
//
// req channel: one payload byte (or an empty-frame marker) per beat, with
// frame id, timestamp and frame size. A byte is taken every cycle but for a
// held-off closing beat; crc and counters update in the cycle it is accepted.
// rsp channel: 30 header beats per fragment, offsets 0..29, last on 29.
// The first header beat appears in the cycle after the beat that closes the
// fragment. A beat that does not close a fragment is taken even while a
// header is going out; a beat that closes one waits until the previous
// header's last beat is taken. The fragment count comes from a reciprocal
// multiply: the operand is registered on the closing beat, then the quotient,
// well before header offset 20. When the receiver stalls, the current header
// beat holds and only closing beats on req are held off. Synchronous reset
// clears the counters, header output and configuration registers and
// presets the crc to all ones; there is no clearing pass.
// Registers on psel/penable: magic at 0x0, version at 0x4, flags at 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_fragment_header_generator #(
   parameter int unsigned MAX_PAYLOAD_BYTES = ffhg_pkg::MAX_PAYLOAD_BYTES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic                             req_mode,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic [31:0]                      req_frame_id,
   input  wire logic [63:0]                      req_timestamp_us,
   input  wire logic [ffhg_pkg::SIZE_W-1:0]      req_frame_size,

   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [7:0]                       rsp_header_byte,
   output      logic [ffhg_pkg::OFFSET_W-1:0]    rsp_byte_offset,
   output      logic                             rsp_last,

   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ffhg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [ffhg_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [ffhg_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                             pready
);
   import ffhg_pkg::*;

   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD_BYTES);

   // configuration registers
   logic [15:0] magic_ff;
   logic [7:0]  version_ff;
   logic [7:0]  flags_ff;

   // fragmenter state
   logic [31:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [LEN_W-1:0] len_ff, len_in;

   // header held for emission
   logic [31:0]        id_ff;
   logic [63:0]        ts_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [NUM_W-1:0]   index_ff;
   logic [COUNT_W-1:0] plen_ff;
   logic [31:0]        crc_out_ff;
   logic               busy_ff, busy_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   logic [31:0]      crc_next;
   logic [POS_W-1:0] pos_inc, size_ext;
   logic [LEN_W-1:0] len_inc;
   logic             in_range, frame_end, frag_full, would_emit;
   logic             req_fire, rsp_fire, last_fire, load;
   logic             csr_write;

   logic [HDR_BITS-1:0] hdr_vec;
   logic [7:0]          hdr_arr [HDR_LEN];

   div_ctrl_type   div_ctrl;
   div_status_type div_status;

   // ---------------------------------------------------------------- csr
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
         flags_ff   <= '0;
      end else if (csr_write) begin
         unique case (paddr[CSR_ADDR_W-1:2])
            CSR_MAGIC:   magic_ff   <= pwdata[15:0];
            CSR_VERSION: version_ff <= pwdata[7:0];
            CSR_FLAGS:   flags_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1:2])
         CSR_MAGIC:   prdata = CSR_DATA_W'(magic_ff);
         CSR_VERSION: prdata = CSR_DATA_W'(version_ff);
         CSR_FLAGS:   prdata = CSR_DATA_W'(flags_ff);
         default:     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- fragmenter
   assign crc_next   = crc32_byte(crc_ff, req_data_byte);
   assign pos_inc    = pos_ff + POS_W'(1);
   assign len_inc    = len_ff + LEN_W'(1);
   assign size_ext   = POS_W'(req_frame_size);
   assign in_range   = (pos_ff < size_ext);
   assign frame_end  = (pos_inc == size_ext);
   assign frag_full  = (len_inc == MAX_LEN);
   assign would_emit = req_mode | (in_range & (frame_end | frag_full));

   assign rsp_fire  = rsp_valid & rsp_ready;
   assign last_fire = rsp_fire & (offset_ff == LAST_OFFSET);
   // a closing beat needs the header register free by the next edge
   assign req_ready = ~would_emit | ~busy_ff | last_fire;
   assign req_fire  = req_valid & req_ready;
   assign load      = req_fire & would_emit;

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      num_in = num_ff;
      len_in = len_ff;
      if (req_fire) begin
         if (req_mode || !in_range) begin
            // empty marker or byte past the frame: drop the partial frame
            crc_in = CRC_ALL_ONES;
            pos_in = '0;
            num_in = '0;
            len_in = '0;
         end else if (frame_end) begin
            crc_in = CRC_ALL_ONES;
            pos_in = '0;
            num_in = '0;
            len_in = '0;
         end else if (frag_full) begin
            crc_in = CRC_ALL_ONES;
            pos_in = pos_inc;
            num_in = num_ff + NUM_W'(1);
            len_in = '0;
         end else begin
            crc_in = crc_next;
            pos_in = pos_inc;
            len_in = len_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_ALL_ONES;
         pos_ff <= '0;
         num_ff <= '0;
         len_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         num_ff <= num_in;
         len_ff <= len_in;
      end
   end

   // ------------------------------------------------------------- header
   always_ff @(posedge clock) begin
      if (load) begin
         id_ff      <= req_frame_id;
         ts_ff      <= req_timestamp_us;
         size_ff    <= req_mode ? '0 : req_frame_size;
         index_ff   <= req_mode ? '0 : num_ff;
         plen_ff    <= req_mode ? '0 : COUNT_W'(len_inc);
         crc_out_ff <= req_mode ? '0 : ~crc_next;
      end
   end

   assign div_ctrl.start = load;
   assign div_ctrl.empty = req_mode;

   ffhg_ceil_div #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_ceil_div (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (div_ctrl),
      .total_bytes (req_frame_size),
      .status      (div_status)
   );

   always_comb begin
      busy_in   = busy_ff;
      offset_in = offset_ff;
      if (rsp_fire) begin
         if (offset_ff == LAST_OFFSET) begin
            busy_in = 1'b0;
         end else begin
            offset_in = offset_ff + OFFSET_W'(1);
         end
      end
      if (load) begin
         busy_in   = 1'b1;
         offset_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         offset_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         offset_ff <= offset_in;
      end
   end

   assign hdr_vec = {magic_ff, version_ff, flags_ff, id_ff, ts_ff,
                     {(32 - SIZE_W){1'b0}}, size_ff, div_status.quotient,
                     index_ff, plen_ff, crc_out_ff};

   always_comb begin
      for (int i = 0; i < HDR_LEN; i++) begin
         hdr_arr[i] = hdr_vec[HDR_BITS - 1 - 8 * i -: 8];
      end
   end

   // count bytes and every beat after them wait for the divider
   assign rsp_valid       = busy_ff & ((offset_ff < COUNT_OFFSET) | div_status.done);
   assign rsp_header_byte = hdr_arr[offset_ff];
   assign rsp_byte_offset = offset_ff;
   assign rsp_last        = (offset_ff == LAST_OFFSET);

endmodule

`default_nettype wire

// ----- rtl/core/ffhg_ceil_div.sv -----
// ----------------------------------------------------------------------------
// ffhg_ceil_div
// fragment count: ceil(total / MAX_PAYLOAD_BYTES) by reciprocal multiplication,
// operand registered on start, pending flag set, quotient registered from the product later
// ----------------------------------------------------------------------------
`default_nettype none

module ffhg_ceil_div #(
   parameter int unsigned MAX_PAYLOAD_BYTES = ffhg_pkg::MAX_PAYLOAD_BYTES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ffhg_pkg::div_ctrl_type       ctrl,
   input  wire logic [ffhg_pkg::SIZE_W-1:0]  total_bytes,
   output      ffhg_pkg::div_status_type     status
);
   import ffhg_pkg::*;

   // floor(x * RECIP / 2^SHIFT) is exact for every x below 2^DIVIDEND_W
   localparam int unsigned SHIFT   = DIVIDEND_W + $clog2(MAX_PAYLOAD_BYTES);
   localparam int unsigned RECIP_W = DIVIDEND_W + 1;
   localparam int unsigned PROD_W  = SHIFT + COUNT_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(MAX_PAYLOAD_BYTES) - 64'd1) / 64'(MAX_PAYLOAD_BYTES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic                  pend_ff;
   logic [COUNT_W-1:0]    quot_ff;
   logic [PROD_W-1:0]     product;

   assign dividend = DIVIDEND_W'(total_bytes) + DIVIDEND_W'(MAX_PAYLOAD_BYTES - 1);
   // an empty frame always reports a single fragment
   assign num_in   = ctrl.empty ? DIVIDEND_W'(MAX_PAYLOAD_BYTES) : dividend;
   // low bits of the product are exact, only the quotient field is kept
   assign product  = PROD_W'(num_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctrl.start;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         num_ff <= num_in;
      end
      if (pend_ff) begin
         quot_ff <= product[SHIFT +: COUNT_W];
      end
   end

   assign status.done     = ~pend_ff;
   assign status.quotient = quot_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ffhg_checker.sv -----
// ----------------------------------------------------------------------------
// ffhg_checker
// port-level checks on the header beat sequence of the fragment header
// generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_fragment_header_generator_assert.svh"

module ffhg_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [7:0]                     rsp_header_byte,
   input wire logic [ffhg_pkg::OFFSET_W-1:0]  rsp_byte_offset,
   input wire logic                           rsp_last
);
   import ffhg_pkg::*;

   // last marks offset 29 and nothing else
   `FFHG_ASSERT_SAME(a_last_at_end, clock, reset, rsp_valid, rsp_last == (rsp_byte_offset == LAST_OFFSET), "rsp_last does not match header offset")

   // header beats go out in offset order
   `FFHG_ASSERT_NEXT(a_offset_steps, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_byte_offset == $past(rsp_byte_offset) + OFFSET_W'(1), "header offset skipped or repeated")

   // a new header starts at offset zero
   `FFHG_ASSERT_NEXT(a_restart_zero, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid || rsp_byte_offset == '0, "header did not restart at offset zero")

   // a stalled beat holds
   `FFHG_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_header_byte) && $stable(rsp_byte_offset), "stalled header beat changed")

endmodule

bind frame_fragment_header_generator ffhg_checker u_ffhg_checker (.*);

`default_nettype wire

// ----- tb/sv/frag_header_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frag_header_tb_pkg
// Fragment tracker and header scoreboard for the frame fragment header
// generator: follows crc, frame position and fragment index per accepted req
// beat, builds the expected 30 header beats and checks each rsp beat.
// ----------------------------------------------------------------------------
package frag_header_tb_pkg;

   import ffhg_pkg::*;

   typedef struct packed {
      logic [7:0]          header_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic                last;
   } header_beat_type;

   class frag_header_scoreboard;

      logic [15:0]       magic;
      logic [7:0]        version;
      logic [7:0]        flags;

      logic [31:0]       crc;
      logic [POS_W-1:0]  position;
      logic [NUM_W-1:0]  frag_index;
      int unsigned       frag_bytes;
      int unsigned       frag_limit;

      header_beat_type   expected_header_beats[$];
      int unsigned       fault_count;
      int unsigned       beats_seen;

      function new(int unsigned max_payload_bytes);
         frag_limit  = max_payload_bytes;
         magic       = '0;
         version     = '0;
         flags       = '0;
         fault_count = 0;
         beats_seen  = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         crc        = CRC_ALL_ONES;
         position   = '0;
         frag_index = '0;
         frag_bytes = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_MAGIC:   magic   = value[15:0];
            CSR_VERSION: version = value[7:0];
            CSR_FLAGS:   flags   = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(csr_index_type idx);
         case (idx)
            CSR_MAGIC:   return {16'h0000, magic};
            CSR_VERSION: return {24'h000000, version};
            CSR_FLAGS:   return {24'h000000, flags};
            default:     return '0;
         endcase
      endfunction

      function void report(string msg);
         fault_count++;
         if (fault_count <= 10) begin
            $display("%t: %s", $realtime, msg);
         end
      endfunction

      function int unsigned pending();
         return expected_header_beats.size();
      endfunction

      // lsb-first crc over one payload byte
      function logic [31:0] fold_byte(logic [31:0] acc, logic [7:0] b);
         logic [31:0] c;
         c = acc ^ {24'h000000, b};
         for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
               c = (c >> 1) ^ CRC_POLY;
            end else begin
               c = c >> 1;
            end
         end
         return c;
      endfunction

      function void queue_header(logic [31:0] id, logic [63:0] ts, logic [SIZE_W-1:0] size,
                                 logic [15:0] count, logic [15:0] index,
                                 logic [15:0] plen, logic [31:0] body_crc);
         logic [HDR_BITS-1:0] hdr;
         header_beat_type     beat;
         hdr = {magic, version, flags, id, ts, {(32 - SIZE_W){1'b0}}, size,
                count, index, plen, body_crc};
         for (int i = 0; i < HDR_LEN; i++) begin
            beat.header_byte = hdr[HDR_BITS - 1 - 8 * i -: 8];
            beat.byte_offset = OFFSET_W'(i);
            beat.last        = (i == HDR_LEN - 1);
            expected_header_beats = {expected_header_beats, beat};
         end
      endfunction

      function void note_req(logic mode, logic [7:0] data_byte, logic [31:0] id,
                             logic [63:0] ts, logic [SIZE_W-1:0] size);
         logic        frame_done;
         logic [15:0] count;
         if (mode) begin
            restart_frame();
            queue_header(id, ts, '0, 16'd1, 16'd0, 16'd0, 32'd0);
            return;
         end
         // byte past the declared size: dropped, partial frame thrown away
         if (position >= {1'b0, size}) begin
            restart_frame();
            return;
         end
         crc        = fold_byte(crc, data_byte);
         position   = position + 1'b1;
         frag_bytes = frag_bytes + 1;
         frame_done = (position == {1'b0, size});
         if (!frame_done && frag_bytes < frag_limit) begin
            return;
         end
         count = 16'((64'(size) + 64'(frag_limit) - 64'd1) / 64'(frag_limit));
         queue_header(id, ts, size, count, frag_index, 16'(frag_bytes), ~crc);
         crc        = CRC_ALL_ONES;
         frag_bytes = 0;
         frag_index = frag_index + 1'b1;
         if (frame_done) begin
            position   = '0;
            frag_index = '0;
         end
      endfunction

      function void check_rsp(logic [7:0] header_byte, logic [OFFSET_W-1:0] byte_offset,
                              logic last);
         header_beat_type want;
         beats_seen++;
         if (expected_header_beats.size() == 0) begin
            report($sformatf("header beat %0d with none expected: byte %02h offset %0d last %0b",
                             beats_seen, header_byte, byte_offset, last));
            return;
         end
         want = expected_header_beats.pop_front();
         if (want.header_byte !== header_byte || want.byte_offset !== byte_offset ||
             want.last !== last) begin
            report($sformatf({"header beat %0d: expected byte %02h offset %0d last %0b, ",
                              "got byte %02h offset %0d last %0b"},
                             beats_seen, want.header_byte, want.byte_offset, want.last,
                             header_byte, byte_offset, last));
         end
      endfunction

   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the frame fragment header generator. Directed frames cover
// empty markers, dropped bytes, abandoned frames and field extremes; a burst
// with every register bit set runs with no gaps on the sender; random frames
// run under several register settings, with random idling on one or both channels.
// Every header beat is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

   import ffhg_pkg::*;
   import frag_header_tb_pkg::*;

   localparam int unsigned FRAG_MAX   = MAX_PAYLOAD_BYTES_DEFAULT;
   localparam int unsigned IDLE_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_mode         = 1'b0;
   logic [7:0]            req_data_byte    = '0;
   logic [31:0]           req_frame_id     = '0;
   logic [63:0]           req_timestamp_us = '0;
   logic [SIZE_W-1:0]     req_frame_size   = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_header_byte;
   logic [OFFSET_W-1:0]   rsp_byte_offset;
   logic                  rsp_last;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic                  req_steady = 1'b0;
   logic                  rsp_steady = 1'b0;
   int unsigned           rsp_hold_cycles = 0;
   int unsigned           idle_cycles = 0;

   frag_header_scoreboard sb = new(FRAG_MAX);

   frame_fragment_header_generator #(
      .MAX_PAYLOAD_BYTES (FRAG_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .req_frame_id     (req_frame_id),
      .req_timestamp_us (req_timestamp_us),
      .req_frame_size   (req_frame_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog: ends the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no beat accepted for %0d cycles, %0d header beats outstanding",
                     IDLE_LIMIT, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_req(input logic mode, input logic [7:0] data_byte,
                           input logic [31:0] id, input logic [63:0] ts,
                           input logic [SIZE_W-1:0] total);
      int unsigned gap;
      gap = req_steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_data_byte    <= data_byte;
      req_frame_id     <= id;
      req_timestamp_us <= ts;
      req_frame_size   <= total;
      do @(posedge clock); while (!req_ready);
      sb.note_req(mode, data_byte, id, ts, total);
   endtask

   task automatic send_frame(input logic [SIZE_W-1:0] total, input logic [31:0] id,
                             input logic [63:0] ts, input int unsigned nbytes);
      for (int unsigned i = 0; i < nbytes; i++) begin
         send_req(1'b0, 8'($urandom), id, ts, total);
      end
   endtask

   // sender pauses until every header has gone out
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== sb.register_value(idx)) begin
         sb.report($sformatf("register %s read back %08h, expected %08h",
                             idx.name(), readback, sb.register_value(idx)));
      end
      @(posedge clock);
   endtask

   task automatic run_random_frames(input int unsigned item_target);
      int unsigned       sent;
      int unsigned       pick;
      int unsigned       size;
      int unsigned       cut;
      logic [31:0]       id;
      logic [63:0]       ts;
      sent = 0;
      while (sent < item_target) begin
         pick = $urandom_range(0, 99);
         id   = $urandom;
         ts   = {$urandom, $urandom};
         if (pick < 70) begin
            size = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_frame(SIZE_W'(size), id, ts, size);
            sent += size;
         end else if (pick < 82) begin
            send_req(1'b1, 8'($urandom), id, ts, SIZE_W'($urandom));
            sent++;
         end else if (pick < 92) begin
            // frame cut short by a byte whose size is already used up
            size = $urandom_range(3, 12);
            cut  = $urandom_range(1, size - 1);
            send_frame(SIZE_W'(size), id, ts, cut);
            send_req(1'b0, 8'($urandom), id, ts, SIZE_W'($urandom_range(0, cut)));
            sent += cut;
         end else begin
            // huge declared size, abandoned by an empty marker
            cut = $urandom_range(1, 6);
            send_frame(SIZE_W'($urandom_range(64, 32'h03FF_FFFF)), id, ts, cut);
            send_req(1'b1, 8'($urandom), $urandom, {$urandom, $urandom}, SIZE_W'($urandom));
            sent += cut + 1;
         end
      end
   endtask

   // receiver: random gaps per beat, plus one long hold-off
   initial begin
      int unsigned gap;
      forever begin
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = rsp_steady ? 0 : $urandom_range(0, 14);
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         sb.check_rsp(rsp_header_byte, rsp_byte_offset, rsp_last);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames, registers at reset values
      send_req(1'b1, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 26'h3FF_FFFF);
      send_req(1'b0, 8'h00, 32'h0, 64'h0, 26'd1);
      send_req(1'b0, 8'hA5, 32'h1, 64'h1, 26'd0);
      send_req(1'b0, 8'hFF, 32'h8000_0001, 64'h8000_0000_0000_0001, 26'd3);
      send_req(1'b0, 8'h80, 32'h8000_0001, 64'h8000_0000_0000_0001, 26'd3);
      send_req(1'b0, 8'h01, 32'h8000_0001, 64'h8000_0000_0000_0001, 26'd3);
      send_req(1'b0, 8'h12, 32'h7FFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 26'd4);
      send_req(1'b0, 8'h34, 32'h7FFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 26'd4);
      send_req(1'b1, 8'h00, 32'h0, 64'h0, 26'd0);
      send_req(1'b0, 8'h55, 32'h0000_00AA, 64'h00FF, 26'd5);
      send_req(1'b0, 8'hAA, 32'h0000_00AA, 64'h00FF, 26'd5);
      send_req(1'b0, 8'h77, 32'h0000_00AA, 64'h00FF, 26'd1);
      send_req(1'b0, 8'h5A, 32'hDEAD_0001, 64'h0123_4567_89AB_CDEF, 26'd2);
      send_req(1'b0, 8'hC3, 32'hDEAD_0001, 64'h0123_4567_89AB_CDEF, 26'd2);
      drain();

      // all register bits set, sender never idles
      csr_write(CSR_MAGIC, 32'h0000_FFFF);
      csr_write(CSR_VERSION, 32'h0000_00FF);
      csr_write(CSR_FLAGS, 32'h0000_00FF);
      req_steady = 1'b1;
      run_random_frames(20);
      req_steady = 1'b0;
      drain();

      for (int chunk = 0; chunk < 4; chunk++) begin
         if (chunk == 0) begin
            csr_write(CSR_MAGIC, 32'h0);
            csr_write(CSR_VERSION, 32'h0);
            csr_write(CSR_FLAGS, 32'h0);
            rsp_hold_cycles = 300;
         end else begin
            csr_write(CSR_MAGIC, 32'($urandom_range(0, 16'hFFFF)));
            csr_write(CSR_VERSION, 32'($urandom_range(0, 8'hFF)));
            csr_write(CSR_FLAGS, 32'($urandom_range(0, 8'hFF)));
         end
         req_steady = (chunk == 2);
         rsp_steady = (chunk == 3);
         run_random_frames(45);
         drain();
      end

      repeat (32) @(posedge clock);
      if (sb.fault_count == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
